// ===== design/unique_id_registry_defines.svh =====
// ----------------------------------------------------------------------------
// Unique ID registry assertion macros
// Shared macros for the concurrent checks on the registry ports.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ID_REGISTRY_DEFINES_SVH
`define UNIQUE_ID_REGISTRY_DEFINES_SVH

// The antecedent and the consequent are checked in the same cycle.
`define UIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define UIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/uir_pkg.sv =====
// ----------------------------------------------------------------------------
// Unique ID registry package
// Command, set, status and state codes shared by the registry and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uir_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CREATE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SET = 3'd1,
    ST_ZERO    = 3'd2,
    ST_COLLIDE = 3'd3,
    ST_MISSING = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_RESULT
  } state_t;

  localparam logic [1:0] SET_VESSEL = 2'd0;
  localparam logic [1:0] SET_PART   = 2'd1;

  localparam logic REG_RANDOM_SEED = 1'b0;

endpackage

// ===== design/unique_id_registry.sv =====
// ----------------------------------------------------------------------------
// Unique ID registry
// Two tables of unique 32-bit IDs with add, remove and random create commands.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**(clog2(CAPACITY)+1) words of its table
// memory, taking no word until the sweep is done. Each command then scans
// every entry of the chosen table through the single read port of the memory,
// one entry a cycle. An add or a remove then offers its result; a create does
// the same after one more scan of the table for every redraw that hits an ID
// already present. A rejected set or a zero ID on add skips the scan and goes
// straight to the result. One word is worked on at a time; the next is taken
// while the previous result waits at the output.
`timescale 1ns / 1ps

module unique_id_registry
  import uir_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [1:0]  set_select,
  input  logic [31:0] id_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] id_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int AW        = IW + 1;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  function automatic logic [31:0] xs_next(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  logic [32:0] mem [MEM_DEPTH];

  state_t        state, state_next;
  logic [AW-1:0] clr_addr;
  logic [IW-1:0] scan_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [IW-1:0] found_idx;
  logic          has_free;
  logic [IW-1:0] free_idx;
  cmd_t          cmd_r;
  logic          sel_r;
  logic [31:0]   target;
  logic [31:0]   gen;
  logic [31:0]   seed;
  status_t       res_status;
  logic [31:0]   res_id;
  logic [32:0]   rd_data;

  logic          in_acc;
  logic          bad_word;
  logic          issue;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [32:0]   wr_data;
  logic          cfg_wr;
  logic          redraw;
  logic          out_load;

  assign in_acc   = in_valid && in_ready;
  assign bad_word = !(command == CMD_ADD || command == CMD_REMOVE || command == CMD_CREATE)
                    || (set_select != SET_VESSEL && set_select != SET_PART);
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_RANDOM_SEED);
  assign redraw   = (cmd_r == CMD_CREATE) && has_free && ((target == 32'd0) || found);
  assign out_load = (state == S_RESULT) && (!out_valid || out_ready);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RANDOM_SEED) ? seed : 32'd0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (&clr_addr) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (bad_word || (command == CMD_ADD && id_value == 32'd0)) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx == LAST_IDX) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = redraw ? S_SCAN : S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = {sel_r, free_idx};
    wr_data  = {1'b1, target};
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = 33'd0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_SCAN: begin
        issue = 1'b1;
      end
      S_DECIDE: begin
        case (cmd_r)
          CMD_ADD: begin
            wr_en = !found && has_free;
          end
          CMD_REMOVE: begin
            wr_en   = found;
            wr_addr = {sel_r, found_idx};
            wr_data = {1'b0, target};
          end
          CMD_CREATE: begin
            wr_en = has_free && (target != 32'd0) && !found;
          end
          default: wr_en = 1'b0;
        endcase
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[{sel_r, scan_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      gen       <= 32'd1;
      seed      <= 32'd1;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_wr) begin
        seed <= pwdata;
        gen  <= (pwdata != 32'd0) ? pwdata : 32'd1;
      end else if (state == S_DECIDE && cmd_r == CMD_CREATE && has_free) begin
        gen <= target;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r      <= cmd_t'(command);
      sel_r      <= set_select[0];
      target     <= (command == CMD_CREATE) ? xs_next(gen) : id_value;
      res_id     <= (command == CMD_CREATE) ? 32'd0 : id_value;
      res_status <= bad_word ? ST_BAD_SET : ST_ZERO;
      scan_idx   <= '0;
      found      <= 1'b0;
      has_free   <= 1'b0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end else if (state == S_DECIDE) begin
      case (cmd_r)
        CMD_ADD: begin
          if (found) begin
            res_status <= ST_COLLIDE;
          end else if (!has_free) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_OK;
          end
        end
        CMD_REMOVE: begin
          res_status <= found ? ST_OK : ST_MISSING;
        end
        CMD_CREATE: begin
          if (!has_free) begin
            res_status <= ST_FULL;
            res_id     <= 32'd0;
          end else if (redraw) begin
            target   <= xs_next(target);
            scan_idx <= '0;
            found    <= 1'b0;
            has_free <= 1'b0;
          end else begin
            res_status <= ST_OK;
            res_id     <= target;
          end
        end
        default: res_status <= ST_BAD_SET;
      endcase
    end
    if (state == S_SCAN) begin
      pend_idx <= scan_idx;
    end
    if (pend) begin
      if (rd_data[32] && rd_data[31:0] == target && !found) begin
        found     <= 1'b1;
        found_idx <= pend_idx;
      end
      if (!rd_data[32] && !has_free) begin
        has_free <= 1'b1;
        free_idx <= pend_idx;
      end
    end
    if (out_load) begin
      status    <= res_status;
      id_result <= res_id;
    end
  end

endmodule

// ===== design/uir_checker.sv =====
// ----------------------------------------------------------------------------
// Unique ID registry checker
// Port-level checks on results and handshakes, bound to the registry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "unique_id_registry_defines.svh"

module uir_checker
  import uir_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] id_result
);

  `UIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(id_result), "result word changed while stalled")
  `UIR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while one is in progress")
  `UIR_ASSERT_SAME(a_zero_echo, out_valid && status == ST_ZERO, id_result == 32'd0, "zero status with a nonzero ID")
  `UIR_ASSERT_SAME(a_ok_nonzero, out_valid && status == ST_OK, id_result != 32'd0, "success reported for ID zero")

endmodule

bind unique_id_registry uir_checker u_uir_checker (.*);

// ===== dv/tb_unique_id_registry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique ID registry testbench
// Drives add, remove and create words into both registries and into the
// invalid sets. The seed register is set over the APB port between phases.
// A scoreboard class predicts each result from its own copy of the tables
// and of the generator, and checks every result word in order. Both sides
// stall at random, and the last phase runs with no stalls at all.
// ----------------------------------------------------------------------------

module tb_unique_id_registry;
  import uir_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
  localparam int LIMIT_NS = 150_000_000;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] SET_BAD_LO  = 2'd2;
  localparam logic [1:0] SET_BAD_HI  = 2'd3;
  localparam logic [2:0] SEED_ADDR   = {REG_RANDOM_SEED, 2'b00};

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] id;
  } registry_result_t;

  class id_registry_model;
    logic [31:0]      ids [2][CAPACITY];
    bit               valid [2][CAPACITY];
    logic [31:0]      gen_state;
    registry_result_t pending_results [$];
    int               errors;

    function new();
      foreach (valid[s, i]) begin
        valid[s][i] = 1'b0;
        ids[s][i]   = '0;
      end
      gen_state = 32'd1;
      errors    = 0;
    endfunction

    function void load_seed(logic [31:0] seed);
      gen_state = (seed != 32'd0) ? seed : 32'd1;
    endfunction

    function logic [31:0] xorshift(logic [31:0] x);
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      return x;
    endfunction

    function logic [31:0] next_draw_value();
      return xorshift(gen_state);
    endfunction

    function int find_slot(int s, logic [31:0] v);
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid[s][i] && ids[s][i] == v) return i;
      end
      return -1;
    endfunction

    function int free_slot(int s);
      for (int i = 0; i < CAPACITY; i++) begin
        if (!valid[s][i]) return i;
      end
      return -1;
    endfunction

    function logic [31:0] present_id(int s);
      int hits [$];
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid[s][i]) hits.push_back(i);
      end
      if (hits.size() == 0) return $urandom;
      return ids[s][hits[$urandom_range(hits.size() - 1, 0)]];
    endfunction

    function void note_command(logic [1:0] cmd, logic [1:0] sel, logic [31:0] id);
      registry_result_t r;
      int               s;
      int               slot;
      logic [31:0]      v;
      r.st = ST_OK;
      r.id = id;
      s = int'(sel[0]);
      if (cmd == CMD_UNKNOWN || sel > SET_PART) begin
        r.st = ST_BAD_SET;
        if (cmd == CMD_CREATE) r.id = '0;
      end else if (cmd == CMD_ADD) begin
        if (id == 32'd0) begin
          r.st = ST_ZERO;
        end else if (find_slot(s, id) >= 0) begin
          r.st = ST_COLLIDE;
        end else begin
          slot = free_slot(s);
          if (slot < 0) begin
            r.st = ST_FULL;
          end else begin
            ids[s][slot]   = id;
            valid[s][slot] = 1'b1;
          end
        end
      end else if (cmd == CMD_REMOVE) begin
        slot = find_slot(s, id);
        if (slot < 0) r.st = ST_MISSING;
        else valid[s][slot] = 1'b0;
      end else begin
        slot = free_slot(s);
        if (slot < 0) begin
          r.st = ST_FULL;
          r.id = '0;
        end else begin
          do begin
            gen_state = xorshift(gen_state);
            v = gen_state;
          end while (v == 32'd0 || find_slot(s, v) >= 0);
          ids[s][slot]   = v;
          valid[s][slot] = 1'b1;
          r.id = v;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] id);
      registry_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, status %0d id_result %h",
                 $time, st, id);
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.st) begin
        errors++;
        $display("%0t: status expected %0d (%s) actual %0d", $time, e.st, e.st.name(), st);
      end
      if (id !== e.id) begin
        errors++;
        $display("%0t: id_result expected %h actual %h", $time, e.id, id);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [1:0]  set_select;
  logic [31:0] id_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] id_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  id_registry_model model = new();
  bit               quiet = 1'b0;

  unique_id_registry #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .set_select (set_select),
    .id_value   (id_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .id_result  (id_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic send_word(logic [1:0] cmd, logic [1:0] sel, logic [31:0] id);
    command    <= cmd;
    set_select <= sel;
    id_value   <= id;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    model.note_command(cmd, sel, id);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] seed);
    logic [31:0] rd;
    paddr   <= SEED_ADDR;
    pwdata  <= seed;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    model.load_seed(seed);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== seed) begin
      model.errors++;
      $display("%0t: random_seed read back expected %h actual %h", $time, seed, rd);
    end
  endtask

  task automatic send_random(mix_t mix, logic [1:0] target);
    int          pick;
    int          w_add;
    int          w_rem;
    int          w_cre;
    int          s;
    logic [1:0]  cmd;
    logic [1:0]  sel;
    logic [31:0] id;
    case (mix)
      MIX_FILL: begin
        w_add = 50; w_rem = 10; w_cre = 30;
      end
      MIX_DRAIN: begin
        w_add = 15; w_rem = 65; w_cre = 10;
      end
      default: begin
        w_add = 35; w_rem = 30; w_cre = 25;
      end
    endcase
    if (mix != MIX_BALANCED && $urandom_range(9, 0) != 0) sel = target;
    else sel = $urandom_range(1, 0) ? SET_PART : SET_VESSEL;
    s    = int'(sel[0]);
    id   = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < w_add) begin
      cmd = CMD_ADD;
      pick = $urandom_range(9, 0);
      if (pick == 0) id = 32'd0;
      else if (pick < 3) id = model.present_id(s);
      else if (pick == 3) id = model.next_draw_value();
    end else if (pick < w_add + w_rem) begin
      cmd = CMD_REMOVE;
      if ($urandom_range(9, 0) < 7) id = model.present_id(s);
      else if ($urandom_range(4, 0) == 0) id = 32'd0;
    end else if (pick < w_add + w_rem + w_cre) begin
      cmd = CMD_CREATE;
    end else begin
      cmd = 2'($urandom_range(3, 0));
      if (cmd != CMD_UNKNOWN) sel = $urandom_range(1, 0) ? SET_BAD_LO : SET_BAD_HI;
      else sel = 2'($urandom_range(3, 0));
    end
    send_word(cmd, sel, id);
  endtask

  task automatic run_directed();
    // The first create runs on the seed left by reset.
    send_word(CMD_CREATE, SET_VESSEL, 32'h0000_0000);
    send_word(CMD_ADD, SET_VESSEL, 32'h0000_0000);
    send_word(CMD_ADD, SET_VESSEL, 32'hFFFF_FFFF);
    send_word(CMD_ADD, SET_VESSEL, 32'hFFFF_FFFF);
    send_word(CMD_ADD, SET_PART, 32'hFFFF_FFFF);
    send_word(CMD_REMOVE, SET_VESSEL, 32'h0000_0000);
    send_word(CMD_REMOVE, SET_VESSEL, 32'hFFFF_FFFF);
    send_word(CMD_REMOVE, SET_VESSEL, 32'hFFFF_FFFF);
    send_word(CMD_ADD, SET_BAD_LO, 32'h0000_0005);
    send_word(CMD_REMOVE, SET_BAD_HI, 32'hFFFF_FFFF);
    send_word(CMD_CREATE, SET_BAD_LO, 32'h0000_1234);
    send_word(CMD_CREATE, SET_BAD_HI, 32'hFFFF_FFFF);
    send_word(CMD_UNKNOWN, SET_VESSEL, 32'hA5A5_A5A5);
    send_word(CMD_UNKNOWN, SET_BAD_HI, 32'h5A5A_5A5A);
    send_word(CMD_ADD, SET_PART, 32'h0000_0001);
    // Planting the next draw forces the create after it to redraw.
    send_word(CMD_ADD, SET_PART, model.next_draw_value());
    send_word(CMD_CREATE, SET_PART, 32'h0000_0000);
    send_word(CMD_ADD, SET_VESSEL, 32'h8000_0000);
    send_word(CMD_ADD, SET_VESSEL, 32'h7FFF_FFFF);
    send_word(CMD_REMOVE, SET_PART, 32'h0000_0001);
    send_word(CMD_ADD, SET_PART, 32'h0000_0001);
    drain_results();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
        model.check_result(status, id_result);
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(4, 0) == 0) stall_left = $urandom_range(7, 1);
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= CMD_ADD;
    set_select <= SET_VESSEL;
    id_value   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= SEED_ADDR;
    pwdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    write_seed(32'h0000_0000);
    repeat (110) send_random(MIX_FILL, SET_VESSEL);
    drain_results();

    write_seed(32'hFFFF_FFFF);
    repeat (110) send_random(MIX_FILL, SET_PART);
    drain_results();

    write_seed($urandom);
    repeat (100) send_random(MIX_DRAIN, $urandom_range(1, 0) ? SET_PART : SET_VESSEL);
    drain_results();

    write_seed(32'h0000_0001);
    quiet = 1'b1;
    repeat (60) send_random(MIX_BALANCED, SET_VESSEL);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (model.errors == 0) $display("tb_unique_id_registry: done, clean");
    else $display("tb_unique_id_registry: done, errors");
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("tb_unique_id_registry: done, errors");
    $finish;
  end

endmodule
